### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### rtl/core/mt64_pkg.sv
// Package for the 64-bit Mersenne Twister core: constants, opcodes, functions.
// Depends on nothing.
package mt64_pkg;
  localparam int TW_N = 312;
  localparam int TW_M = 156;
  localparam int KEY_DEPTH_DEF = 16;
  localparam int AW = 9;
  localparam logic [63:0] SEED_MULT = 64'd6364136223846793005;
  localparam logic [63:0] MIX_MULT_A = 64'd3935559000370003845;
  localparam logic [63:0] MIX_MULT_B = 64'd2862933555777941757;
  localparam logic [63:0] ARRAY_BASE_SEED = 64'd19650218;
  localparam logic [63:0] DEFAULT_SEED = 64'd5489;
  localparam logic [63:0] TWIST_XOR = 64'hB5026F5AA96619E9;
  localparam logic [63:0] UPPER_MASK = 64'hFFFFFFFF80000000;
  localparam logic [63:0] LOWER_MASK = 64'h000000007FFFFFFF;
  localparam logic [8:0] POS_NEVER = 9'd313;
  localparam logic [8:0] POS_FULL = 9'd312;

  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_KEY = 2'd1;
  localparam logic [1:0] OP_DRAW = 2'd2;

  function automatic logic [63:0] spread(input logic [63:0] v);
    spread = v ^ (v >> 62);
  endfunction

  function automatic logic [63:0] twist_one(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic [63:0] far);
    logic [63:0] y;
    y = (hi & UPPER_MASK) | (lo & LOWER_MASK);
    twist_one = far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 64'd0);
  endfunction

  function automatic logic [63:0] temper(input logic [63:0] v);
    logic [63:0] y;
    y = v;
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    temper = y ^ (y >> 43);
  endfunction
endpackage

### rtl/core/mt64_mul.sv
// 64x64 low-half multiplier, three 32x32 partial products over pipelined stages.
// Depends on nothing; done is raised together with the registered result.
module mt64_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);
  logic [63:0] ll_r, lh_r, hl_r;
  logic [63:0] ll2_r;
  logic [31:0] cross_r;
  logic [2:0]  vld_r;

  // Stage one: the three partial products that reach the low 64 bits.
  always_ff @(posedge clk) begin
    ll_r <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh_r <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
    hl_r <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
    ll2_r <= ll_r;
    cross_r <= lh_r[31:0] + hl_r[31:0];
    p <= ll2_r + {cross_r, 32'd0};
  end

  // Valid pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end
  assign done = vld_r[2];
endmodule

### rtl/core/mt64_ctrl.sv
// Sequencer and state memory of the Mersenne Twister core.
// Depends on mt64_pkg and mt64_mul.
module mt64_ctrl
  import mt64_pkg::*;
#(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  req_op,
  input  logic [63:0] req_word,
  input  logic        req_last,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [63:0] res_word,
  output logic        res_wvalid,
  output logic        res_ovf
);
  localparam int KW = $clog2(KEY_DEPTH + 1);
  localparam int KA = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAL  = 8'b00000010,
    S_MIXRD = 8'b00000100,
    S_MIXMU = 8'b00001000,
    S_FIX0  = 8'b00010000,
    S_TWRD  = 8'b00100000,
    S_TWWR  = 8'b01000000,
    S_OUTRD = 8'b10000000
  } st_t;

  st_t st_r;
  logic [63:0] mem [TW_N];
  logic [63:0] kmem [KEY_DEPTH];
  logic [63:0] rd_r, kd_r;
  logic [8:0] pos_r, p_r;
  logic [KW-1:0] kcnt_r, q_r;
  logic ovf_r;
  logic [1:0] phase_r;   // 0 scalar only, 1 key mixing, 2 second mixing, 3 scalar fill then twist
  logic [9:0] t_r;
  logic draw_r;
  logic [63:0] prev_r, cur_r, far_r;
  logic [1:0] tw_r;
  logic mstart;
  logic [63:0] ma, mb, mp;
  logic mdone;
  logic [63:0] res_word_r;
  logic res_wv_r, res_ovf_r, res_v_r;
  logic [8:0] nk;

  mt64_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                  .done(mdone), .p(mp));

  assign req_ready = (st_r == S_IDLE) && !res_v_r;
  assign res_valid = res_v_r;
  assign res_word = res_word_r;
  assign res_wvalid = res_wv_r;
  assign res_ovf = res_ovf_r;
  assign mb = (phase_r == 2'd1) ? MIX_MULT_A : (phase_r == 2'd2) ? MIX_MULT_B : SEED_MULT;
  assign ma = spread(prev_r);
  assign mstart = (st_r == S_SCAL && tw_r == 2'd0) || (st_r == S_MIXMU && tw_r == 2'd0);
  assign nk = (p_r + 9'd1 >= 9'(TW_N)) ? 9'd0 : p_r + 9'd1;

  // Main sequencer: memory reads land in their register in the cycle after the address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pos_r <= POS_NEVER;
      kcnt_r <= '0;
      ovf_r <= 1'b0;
      res_v_r <= 1'b0;
      tw_r <= '0;
      phase_r <= '0;
      draw_r <= 1'b0;
    end else begin
      if (res_v_r && res_ready) res_v_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            res_word_r <= '0;
            res_wv_r <= (req_op == OP_DRAW);
            if (req_op == OP_SEED) begin
              res_ovf_r <= 1'b0;
              kcnt_r <= '0;
              ovf_r <= 1'b0;
              mem[0] <= req_word;
              prev_r <= req_word;
              p_r <= 9'd1;
              phase_r <= 2'd0;
              tw_r <= '0;
              st_r <= S_SCAL;
            end else if (req_op == OP_KEY) begin
              logic [KW-1:0] kc;
              logic of;
              kc = kcnt_r;
              of = ovf_r;
              if (kcnt_r < KW'(KEY_DEPTH)) begin
                kmem[kcnt_r[KA-1:0]] <= req_word;
                kc = kcnt_r + KW'(1);
              end else begin
                of = 1'b1;
              end
              res_ovf_r <= of;
              if (req_last) begin
                kcnt_r <= kc;
                ovf_r <= 1'b0;
                mem[0] <= ARRAY_BASE_SEED;
                prev_r <= ARRAY_BASE_SEED;
                p_r <= 9'd1;
                phase_r <= 2'd0;
                tw_r <= '0;
                draw_r <= 1'b1;   // marks array seeding pending
                st_r <= S_SCAL;
              end else begin
                kcnt_r <= kc;
                ovf_r <= of;
                res_v_r <= 1'b1;
              end
            end else if (req_op == OP_DRAW) begin
              res_ovf_r <= 1'b0;
              if (pos_r == POS_NEVER) begin
                mem[0] <= DEFAULT_SEED;
                prev_r <= DEFAULT_SEED;
                p_r <= 9'd1;
                phase_r <= 2'd3;  // scalar fill, then twist
                tw_r <= '0;
                st_r <= S_SCAL;
              end else if (pos_r == POS_FULL) begin
                p_r <= '0;
                tw_r <= '0;
                st_r <= S_TWRD;
              end else begin
                rd_r <= mem[pos_r];
                st_r <= S_OUTRD;
              end
            end else begin
              res_ovf_r <= 1'b0;
              res_v_r <= 1'b1;
            end
          end
        end
        // Scalar fill: one multiply per word.
        S_SCAL: begin
          if (tw_r == 2'd0) begin
            tw_r <= 2'd1;
          end else if (mdone) begin
            logic [63:0] w;
            w = mp + {55'd0, p_r};
            mem[p_r] <= w;
            tw_r <= '0;
            if (p_r == 9'(TW_N - 1)) begin
              if (phase_r == 2'd3) begin
                p_r <= '0;
                st_r <= S_TWRD;
              end else if (draw_r && kcnt_r != '0) begin
                draw_r <= 1'b0;
                phase_r <= 2'd1;
                p_r <= 9'd1;
                q_r <= '0;
                t_r <= '0;
                prev_r <= mem[0];
                st_r <= S_MIXRD;
              end else begin
                draw_r <= 1'b0;
                kcnt_r <= '0;
                pos_r <= POS_FULL;
                res_v_r <= 1'b1;
                st_r <= S_IDLE;
              end
            end else begin
              prev_r <= w;
              p_r <= p_r + 9'd1;
            end
          end
        end
        // Mixing: read current word and key word.
        S_MIXRD: begin
          cur_r <= mem[p_r];
          kd_r <= kmem[q_r[KA-1:0]];
          tw_r <= '0;
          st_r <= S_MIXMU;
        end
        // Word zero mirrors the last word on wrap; it is only carried in prev_r,
        // since mixing never reads it and the final step overwrites it.
        S_MIXMU: begin
          if (tw_r == 2'd0) begin
            tw_r <= 2'd1;
          end else if (mdone) begin
            logic [63:0] w;
            logic [9:0] tot;
            tot = (phase_r == 2'd1) ? 10'(TW_N) : 10'(TW_N - 1);
            if (phase_r == 2'd1)
              w = (cur_r ^ mp) + kd_r + {{(64 - KW){1'b0}}, q_r};
            else
              w = (cur_r ^ mp) - {55'd0, p_r};
            mem[p_r] <= w;
            prev_r <= w;
            if (p_r == 9'(TW_N - 1)) begin
              p_r <= 9'd1;
            end else begin
              p_r <= p_r + 9'd1;
            end
            if (q_r + KW'(1) >= kcnt_r) q_r <= '0;
            else q_r <= q_r + KW'(1);
            if (t_r + 10'd1 == tot) begin
              t_r <= '0;
              if (phase_r == 2'd1) begin
                phase_r <= 2'd2;
                st_r <= S_MIXRD;
              end else begin
                st_r <= S_FIX0;
              end
            end else begin
              t_r <= t_r + 10'd1;
              st_r <= S_MIXRD;
            end
          end
        end
        S_FIX0: begin
          mem[0] <= 64'h8000000000000000;
          kcnt_r <= '0;
          pos_r <= POS_FULL;
          res_v_r <= 1'b1;
          st_r <= S_IDLE;
        end
        // Twist: read word p, p+1 and p+M in turn, then write.
        S_TWRD: begin
          case (tw_r)
            2'd0: begin
              cur_r <= mem[p_r];
              tw_r <= 2'd1;
            end
            2'd1: begin
              prev_r <= mem[nk];
              tw_r <= 2'd2;
            end
            default: begin
              far_r <= mem[(p_r + 9'(TW_M) >= 9'(TW_N)) ? p_r + 9'(TW_M) - 9'(TW_N)
                                                       : p_r + 9'(TW_M)];
              tw_r <= 2'd0;
              st_r <= S_TWWR;
            end
          endcase
        end
        S_TWWR: begin
          mem[p_r] <= twist_one(cur_r, prev_r, far_r);
          if (p_r == 9'(TW_N - 1)) begin
            pos_r <= '0;
            st_r <= S_OUTRD;
            rd_r <= mem[0];
          end else begin
            p_r <= p_r + 9'd1;
            st_r <= S_TWRD;
          end
        end
        S_OUTRD: begin
          res_word_r <= temper(rd_r);
          pos_r <= ((pos_r == POS_FULL) ? 9'd0 : pos_r) + 9'd1;
          res_v_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/mersenne_twister_64_generator_core.sv
// Top level of the 64-bit Mersenne Twister core.
// A draw's result is registered in S_OUTRD; a draw that finds every word used first
// twists the whole memory. One request is in flight: a new one is taken only once
// the last result has been accepted. Scalar seeding, array seeding and a first draw
// without a seed run their words through the one shared multiplier.
// Synchronous active-low reset marks the state as never seeded.
module mersenne_twister_64_generator_core
  import mt64_pkg::*;
#(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // seed_word
  input  logic        in_tlast,   // key_last
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // rand_word
  output logic [1:0]  out_tuser   // bit 0 word_valid, bit 1 key_overflow
);
  logic wv, ov;

  mt64_ctrl #(.KEY_DEPTH(KEY_DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_tvalid), .req_ready(in_tready), .req_op(in_tuser),
    .req_word(in_tdata), .req_last(in_tlast),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_word(out_tdata),
    .res_wvalid(wv), .res_ovf(ov)
  );
  assign out_tuser = {ov, wv};
endmodule

### rtl/core/mt64_checker.sv
// Port-level checker for the Mersenne Twister core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module mt64_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  `ASSERT_IMPL(a_nozero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == 64'd0)
  `ASSERT_IMPL(a_excl, clk, rst_n, out_tvalid, !(out_tuser[0] && out_tuser[1]))
  `ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule

bind mersenne_twister_64_generator_core mt64_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

### test/testbench.sv
// Self-checking testbench for the 64-bit Mersenne Twister core.
// Depends on mt64_pkg and mersenne_twister_64_generator_core.
module testbench;
  import mt64_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3000000;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] word;
    logic        last;
    bit          drain;
  } req_t;

  typedef struct {
    logic [63:0] word;
    logic        valid;
    logic        ovf;
  } draw_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // seed_word
  logic        in_tlast;   // key_last
  logic [1:0]  in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // rand_word
  logic [1:0]  out_tuser;  // bit 0 word_valid, bit 1 key_overflow

  req_t  pending[$];
  draw_t expected[$];
  int    errors = 0;
  int    received = 0;
  int    cycles = 0;
  int    gap = 0;
  int    burst = 0;
  int    hold = 0;
  bit    long_hold_done = 0;

  // Predictor state.
  logic [63:0] tw[TW_N];
  int          tw_pos;
  logic [63:0] key_mem[KEY_DEPTH_DEF];
  int          key_cnt;
  logic        ovf_seen;

  mersenne_twister_64_generator_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] fold62(logic [63:0] v);
    return v ^ (v >> 62);
  endfunction

  task automatic seed_scalar(logic [63:0] v);
    tw[0] = v;
    for (int p = 1; p < TW_N; p++) tw[p] = SEED_MULT * fold62(tw[p-1]) + 64'(p);
    tw_pos = TW_N;
  endtask

  task automatic seed_keys(int n);
    int p;
    int q;
    int passes;
    p = 1;
    q = 0;
    seed_scalar(ARRAY_BASE_SEED);
    passes = (n > TW_N) ? n : TW_N;
    for (int t = 0; t < passes; t++) begin
      tw[p] = (tw[p] ^ (MIX_MULT_A * fold62(tw[p-1]))) + key_mem[q] + 64'(q);
      p++;
      q++;
      if (p >= TW_N) begin
        tw[0] = tw[TW_N-1];
        p = 1;
      end
      if (q >= n) q = 0;
    end
    for (int t = 0; t < TW_N - 1; t++) begin
      tw[p] = (tw[p] ^ (MIX_MULT_B * fold62(tw[p-1]))) - 64'(p);
      p++;
      if (p >= TW_N) begin
        tw[0] = tw[TW_N-1];
        p = 1;
      end
    end
    tw[0] = 64'h8000000000000000;
    tw_pos = TW_N;
  endtask

  function automatic logic [63:0] mix_pair(logic [63:0] hi, logic [63:0] lo, logic [63:0] far);
    logic [63:0] y;
    y = (hi & UPPER_MASK) | (lo & LOWER_MASK);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 64'd0);
  endfunction

  task automatic next_word(output logic [63:0] r);
    logic [63:0] y;
    if (tw_pos >= TW_N) begin
      if (tw_pos != TW_N) seed_scalar(DEFAULT_SEED);
      for (int p = 0; p < TW_N - 1; p++) tw[p] = mix_pair(tw[p], tw[p+1], tw[(p+TW_M)%TW_N]);
      tw[TW_N-1] = mix_pair(tw[TW_N-1], tw[0], tw[TW_M-1]);
      tw_pos = 0;
    end
    y = tw[tw_pos];
    tw_pos++;
    y ^= (y >> 29) & 64'h5555555555555555;
    y ^= (y << 17) & 64'h71D67FFFEDA60000;
    y ^= (y << 37) & 64'hFFF7EEE000000000;
    r = y ^ (y >> 43);
  endtask

  // Expected result of one accepted request, advancing the predictor.
  task automatic predict_request(logic [1:0] op, logic [63:0] w, logic last);
    draw_t e;
    e = '{64'd0, 1'b0, 1'b0};
    case (op)
      OP_SEED: begin
        key_cnt = 0;
        ovf_seen = 1'b0;
        seed_scalar(w);
      end
      OP_KEY: begin
        if (key_cnt < KEY_DEPTH_DEF) begin
          key_mem[key_cnt] = w;
          key_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
        e.ovf = ovf_seen;
        if (last) begin
          seed_keys(key_cnt);
          key_cnt = 0;
          ovf_seen = 1'b0;
        end
      end
      OP_DRAW: begin
        next_word(e.word);
        e.valid = 1'b1;
      end
      default: ;
    endcase
    expected.push_back(e);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %h want %h", received, what, got, want);
  endtask

  task automatic add_req(logic [1:0] op, logic [63:0] w, logic last);
    pending.push_back('{op, w, last, 1'b0});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Stimulus: directed cases, then random traffic.
  initial begin
    int n;
    int len;
    bit drain_marked;
    rst_n = 1'b0;
    drain_marked = 1'b0;
    add_req(OP_DRAW, 64'd0, 1'b0);          // draw before any seed
    add_req(OP_DRAW, '1, 1'b1);
    add_req(2'd3, '1, 1'b1);                // unused op code
    add_req(OP_SEED, 64'd0, 1'b0);
    add_req(OP_DRAW, 64'd0, 1'b0);
    add_req(OP_SEED, '1, 1'b1);
    add_req(OP_DRAW, 64'd0, 1'b0);
    add_req(OP_KEY, '1, 1'b1);              // single-word key
    add_req(OP_DRAW, 64'd0, 1'b0);
    add_req(OP_KEY, 64'd0, 1'b0);
    add_req(OP_KEY, 64'h123, 1'b0);
    add_req(OP_SEED, 64'd42, 1'b0);         // seed discards a partial key
    add_req(OP_DRAW, 64'd0, 1'b0);
    add_req(OP_KEY, rand64(), 1'b0);
    add_req(OP_DRAW, rand64(), 1'b1);       // draw in the middle of a key
    add_req(OP_KEY, rand64(), 1'b1);
    add_req(OP_DRAW, 64'd0, 1'b0);
    add_req(2'd3, 64'd0, 1'b0);
    n = pending.size();
    while (n < 1400) begin
      case ($urandom_range(0, 19))
        0: begin
          add_req(OP_SEED, rand64(), 1'($urandom));
          n++;
        end
        1, 2: begin
          // Key sequence, sometimes past the store depth, sometimes broken.
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) add_req(OP_DRAW, rand64(), 1'($urandom));
            add_req(OP_KEY, rand64(), k == len - 1);
          end
          if ($urandom_range(0, 7) == 0) add_req(OP_SEED, rand64(), 1'b0);
          n += len;
        end
        3: begin
          add_req(2'd3, rand64(), 1'($urandom));
          n++;
        end
        4: begin
          // Long run of draws through at least one twist.
          for (int k = 0; k < 330; k++) add_req(OP_DRAW, rand64(), 1'($urandom));
          n += 330;
        end
        default: begin
          len = $urandom_range(1, 40);
          for (int k = 0; k < len; k++) add_req(OP_DRAW, rand64(), 1'($urandom));
          n += len;
        end
      endcase
      if (!drain_marked && n > 700) begin
        pending[pending.size()-1].drain = 1'b1;
        drain_marked = 1'b1;
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending.size() == 0 && !in_tvalid && expected.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Driver: offers pending requests with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      in_tuser <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0 &&
                   (!pending[0].drain ||
                    (expected.size() == 0 && !(in_tvalid && in_tready)))) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending[0].word;
        in_tlast <= pending[0].last;
        in_tuser <= pending[0].op;
        void'(pending.pop_front());
        if (burst > 0) begin
          burst <= burst - 1;
          gap <= 0;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:59]: gap <= 0;
            [60:94]: gap <= $urandom_range(1, 3);
            [95:97]: gap <= $urandom_range(20, 120);
            default: burst <= $urandom_range(20, 80);
          endcase
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver readiness, with one long hold-off while requests keep coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && received >= 200) begin
      long_hold_done <= 1'b1;
      hold <= 3000;
      out_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: out_tready <= 1'b1;
        [70:96]: begin
          out_tready <= 1'b0;
          hold <= $urandom_range(0, 3);
        end
        default: begin
          out_tready <= 1'b0;
          hold <= $urandom_range(20, 150);
        end
      endcase
    end
  end

  // Scoreboard: predict accepted requests, check accepted results.
  always @(posedge clk) begin
    if (!rst_n) begin
      tw_pos = POS_NEVER;
      key_cnt = 0;
      ovf_seen = 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected.size() == 0) begin
          report("unexpected result", out_tdata, 64'd0);
        end else begin
          if (out_tdata !== expected[0].word) report("rand_word", out_tdata, expected[0].word);
          if (out_tuser[0] !== expected[0].valid)
            report("word_valid", 64'(out_tuser[0]), 64'(expected[0].valid));
          if (out_tuser[1] !== expected[0].ovf)
            report("key_overflow", 64'(out_tuser[1]), 64'(expected[0].ovf));
          void'(expected.pop_front());
        end
        received++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mt64_pkg.sv
rtl/core/mt64_mul.sv
rtl/core/mt64_ctrl.sv
rtl/core/mersenne_twister_64_generator_core.sv
rtl/core/mt64_checker.sv
test/testbench.sv
